@@ hdl/nmea_sentence_framer_assert.svh @@
// assertion macros for the nmea sentence framer
// used by the front end, the command queue and the back end
`ifndef NMEA_SENTENCE_FRAMER_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS

`define NSF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nsf assertion failed");

`define NSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsf assertion failed");

`else

`define NSF_ASSERT(label, clk, rst_n, prop)

`define NSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/nsf_pkg.sv @@
// shared types, character codes and status codes of the nmea sentence framer
// no dependencies
`timescale 1ns / 1ps

package nsf_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_IN_FRAME = 3'd1;
    localparam logic [2:0] ST_GOOD     = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_MISS_CR  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // what the back end has to do with one word
    typedef enum logic [3:0] {
        K_HUNT_IDLE,
        K_START,
        K_OVERFLOW,
        K_STORE_XOR,
        K_STORE_PLAIN,
        K_CHK_HIGH,
        K_CHK_LOW,
        K_MISS_CR,
        K_WAIT,
        K_LF
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] pos;
        logic [8:0] len;
    } t_cmd;

    // upper-case ascii hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'b0, nib};
        end else begin
            return 8'h37 + {4'b0, nib};
        end
    endfunction

endpackage

@@ hdl/nsf_rx_if.sv @@
// valid/ready channel carrying one received character
// no dependencies
`timescale 1ns / 1ps

interface nsf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hdl/nsf_res_if.sv @@
// valid/ready channel carrying one framer result
// no dependencies
`timescale 1ns / 1ps

interface nsf_res_if;
    logic       valid;
    logic       ready;
    logic       byte_stored;
    logic [7:0] frame_byte;
    logic [7:0] byte_position;
    logic [2:0] status;
    logic [8:0] frame_length;

    modport source (output valid, output byte_stored, output frame_byte,
                    output byte_position, output status, output frame_length,
                    input ready);
    modport sink (input valid, input byte_stored, input frame_byte,
                  input byte_position, input status, input frame_length,
                  output ready);
endinterface

@@ hdl/nsf_front.sv @@
// front end: accepts characters, tracks frame position and star position,
// and classifies each word into a command; uses nsf_pkg and nsf_rx_if
`timescale 1ns / 1ps
`include "nmea_sentence_framer_assert.svh"

module nsf_front #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsf_rx_if.sink        i_rx,
    input  logic          i_q_full,
    output logic          o_push,
    output nsf_pkg::t_cmd o_cmd
);
    import nsf_pkg::*;

    localparam int PW = $clog2(MAX_PAYLOAD + 7);

    logic [PW-1:0] r_position, n_position;
    logic [PW-1:0] r_star, n_star;
    logic [7:0]    w_c;
    t_kind         w_kind;
    logic [PW+7:0] w_pos_wide;
    logic [PW+8:0] w_len_wide;

    assign w_c        = i_rx.rx_byte;
    // no word is taken while reset is held
    assign i_rx.ready = i_rst_n && !i_q_full;
    assign o_push     = i_rx.valid && i_rx.ready;

    assign w_pos_wide = {8'b0, r_position};
    assign w_len_wide = {9'b0, r_position} + (PW + 9)'(2);

    always_comb begin
        n_position = r_position;
        n_star     = r_star;
        w_kind     = K_HUNT_IDLE;
        priority if (r_position == '0) begin
            n_star = PW'(MAX_PAYLOAD);
            if (w_c == CH_DOLLAR) begin
                w_kind     = K_START;
                n_position = PW'(1);
            end
        end else if (r_position > PW'(MAX_PAYLOAD)) begin
            w_kind     = K_OVERFLOW;
            n_position = '0;
        end else if (w_c == CH_STAR) begin
            // a star always restarts the checksum capture here
            w_kind     = K_STORE_PLAIN;
            n_star     = r_position;
            n_position = r_position + PW'(1);
        end else if (r_position == r_star + PW'(1)) begin
            w_kind     = K_CHK_HIGH;
            n_position = r_position + PW'(1);
        end else if (r_position == r_star + PW'(2)) begin
            w_kind     = K_CHK_LOW;
            n_position = r_position + PW'(1);
        end else if (r_position == r_star + PW'(3)) begin
            if (w_c == CH_CR) begin
                w_kind     = K_STORE_PLAIN;
                n_position = r_position + PW'(1);
            end else begin
                w_kind     = K_MISS_CR;
                n_position = '0;
            end
        end else if (r_position == r_star + PW'(4)) begin
            if (w_c == CH_LF) begin
                w_kind     = K_LF;
                n_position = '0;
            end else begin
                w_kind = K_WAIT;
            end
        end else begin
            w_kind     = K_STORE_XOR;
            n_position = r_position + PW'(1);
        end
    end

    assign o_cmd.kind = w_kind;
    assign o_cmd.data = w_c;
    assign o_cmd.pos  = w_pos_wide[7:0];
    assign o_cmd.len  = w_len_wide[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_star     <= PW'(MAX_PAYLOAD);
        end else if (o_push) begin
            r_position <= n_position;
            r_star     <= n_star;
        end
    end

    `NSF_ASSERT(a_pos_bound, i_clk, i_rst_n, r_position <= PW'(MAX_PAYLOAD + 1))
    `NSF_ASSERT_NEXT(a_overflow_rehunt, i_clk, i_rst_n, o_push && w_kind == K_OVERFLOW, r_position == '0)

endmodule

@@ hdl/nsf_queue.sv @@
// short command queue between the front end and the back end
// uses nsf_pkg
`timescale 1ns / 1ps
`include "nmea_sentence_framer_assert.svh"

module nsf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nsf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output nsf_pkg::t_cmd o_cmd
);
    import nsf_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `NSF_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH))

endmodule

@@ hdl/nsf_back.sv @@
// back end: keeps the running xor and received checksum characters,
// builds each result word into the output register; uses nsf_pkg, nsf_res_if
`timescale 1ns / 1ps
`include "nmea_sentence_framer_assert.svh"

module nsf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  nsf_pkg::t_cmd i_cmd,
    output logic          o_pop,
    nsf_res_if.source     o_res
);
    import nsf_pkg::*;

    logic [7:0] r_xor, n_xor;
    logic [7:0] r_chk_high, n_chk_high;
    logic [7:0] r_chk_low, n_chk_low;
    logic       r_out_valid;
    logic       r_stored, n_stored;
    logic [7:0] r_frame_byte, n_frame_byte;
    logic [7:0] r_byte_pos, n_byte_pos;
    logic [2:0] r_status, n_status;
    logic [8:0] r_frame_len, n_frame_len;
    logic       w_good;

    assign o_pop  = i_valid && (!r_out_valid || o_res.ready);
    assign w_good = (r_chk_high == hex_char(r_xor[7:4]))
                 && (r_chk_low == hex_char(r_xor[3:0]));

    always_comb begin
        n_xor        = r_xor;
        n_chk_high   = r_chk_high;
        n_chk_low    = r_chk_low;
        n_stored     = 1'b1;
        n_frame_byte = i_cmd.data;
        n_byte_pos   = i_cmd.pos;
        n_status     = ST_IN_FRAME;
        n_frame_len  = '0;
        unique case (i_cmd.kind)
            K_HUNT_IDLE: begin
                n_xor    = '0;
                n_stored = 1'b0;
                n_status = ST_IDLE;
            end
            K_START: begin
                n_xor = '0;
            end
            K_OVERFLOW: begin
                n_stored = 1'b0;
                n_status = ST_OVERFLOW;
            end
            K_STORE_XOR: begin
                n_xor = r_xor ^ i_cmd.data;
            end
            K_STORE_PLAIN: begin
            end
            K_CHK_HIGH: begin
                n_chk_high = i_cmd.data;
            end
            K_CHK_LOW: begin
                n_chk_low = i_cmd.data;
            end
            K_MISS_CR: begin
                n_stored = 1'b0;
                n_status = ST_MISS_CR;
            end
            K_WAIT: begin
                n_stored = 1'b0;
            end
            K_LF: begin
                n_status    = w_good ? ST_GOOD : ST_MISMATCH;
                n_frame_len = i_cmd.len;
            end
            default: begin
                n_stored = 1'b0;
            end
        endcase
        // dropped words carry no byte and no position
        if (!n_stored) begin
            n_frame_byte = '0;
            n_byte_pos   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor       <= '0;
            r_chk_high  <= '0;
            r_chk_low   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_xor      <= n_xor;
                r_chk_high <= n_chk_high;
                r_chk_low  <= n_chk_low;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_stored     <= n_stored;
            r_frame_byte <= n_frame_byte;
            r_byte_pos   <= n_byte_pos;
            r_status     <= n_status;
            r_frame_len  <= n_frame_len;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.byte_stored   = r_stored;
    assign o_res.frame_byte    = r_frame_byte;
    assign o_res.byte_position = r_byte_pos;
    assign o_res.status        = r_status;
    assign o_res.frame_length  = r_frame_len;

    `NSF_ASSERT_NEXT(a_lf_verdict, i_clk, i_rst_n, o_pop && i_cmd.kind == K_LF, (r_status == ST_GOOD || r_status == ST_MISMATCH) && r_frame_byte == CH_LF)
    `NSF_ASSERT(a_drop_clean, i_clk, i_rst_n, (r_out_valid && !r_stored) |-> (r_frame_byte == '0 && r_byte_pos == '0))

endmodule

@@ hdl/nmea_sentence_framer.sv @@
// nmea 0183 sentence framer with checksum check, top level
// uses nsf_pkg, nsf_rx_if, nsf_res_if, nsf_front, nsf_queue, nsf_back
`timescale 1ns / 1ps

// Takes one received character per word and returns exactly one result word for each:
// the character echoed with its frame position when it is stored, and a frame status
// (idle, in frame, good, checksum mismatch, missing CR, overflow drop), with the frame
// length on the LF that closes a sentence. The block sustains one character per clock
// while the result side keeps up: the front end classifies a character in the cycle
// it is accepted, a two-entry command queue parts it from the back end, and the back
// end registers the result, so a result passes through the queue and then the output
// register. Input ready is low during reset and otherwise falls only when the result
// side has stalled long enough to fill the queue. MAX_PAYLOAD sets the highest frame
// position before a frame is dropped as an overflow.
module nmea_sentence_framer #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nsf_rx_if.sink    i_rx,
    nsf_res_if.source o_res
);
    import nsf_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_front_cmd;
    t_cmd w_back_cmd;

    nsf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    nsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_back_cmd)
    );

    nsf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_back_cmd),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for nmea_sentence_framer: directed sentences, then random traffic
// depends on nsf_pkg, nsf_rx_if, nsf_res_if and the framer rtl
`timescale 1ns / 1ps

module testbench;
    import nsf_pkg::*;

    localparam int FRAME_MAX       = 255;
    localparam int RANDOM_ITEMS    = 800;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DIR_COUNT       = 24;

    typedef struct packed {
        logic       stored;
        logic [7:0] data;
        logic [7:0] pos;
        logic [2:0] status;
        logic [8:0] len;
    } t_frame_res;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_frame_res res;
    } t_dir_row;

    localparam t_frame_res NO_RES = '0;

    // typed rows: after reset, good and mismatching frames, ignored byte, missing CR
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        '{8'h00,     1'b1, '{1'b0, 8'h00, 8'd0, ST_IDLE, 9'd0}},
        '{CH_DOLLAR, 1'b1, '{1'b1, CH_DOLLAR, 8'd0, ST_IN_FRAME, 9'd0}},
        '{8'hFF,     1'b0, NO_RES},
        '{CH_STAR,   1'b0, NO_RES},
        '{8'h46,     1'b0, NO_RES},
        '{8'h46,     1'b0, NO_RES},
        '{CH_CR,     1'b0, NO_RES},
        '{CH_LF,     1'b1, '{1'b1, CH_LF, 8'd6, ST_GOOD, 9'd8}},
        '{CH_DOLLAR, 1'b0, NO_RES},
        '{CH_STAR,   1'b0, NO_RES},
        '{8'h30,     1'b0, NO_RES},
        '{8'h30,     1'b0, NO_RES},
        '{CH_CR,     1'b0, NO_RES},
        '{8'h5A,     1'b1, '{1'b0, 8'h00, 8'd0, ST_IN_FRAME, 9'd0}},
        '{CH_STAR,   1'b0, NO_RES},
        '{8'h30,     1'b0, NO_RES},
        '{8'h31,     1'b0, NO_RES},
        '{CH_CR,     1'b0, NO_RES},
        '{CH_LF,     1'b1, '{1'b1, CH_LF, 8'd9, ST_MISMATCH, 9'd11}},
        '{CH_DOLLAR, 1'b0, NO_RES},
        '{CH_STAR,   1'b0, NO_RES},
        '{8'h30,     1'b0, NO_RES},
        '{8'h30,     1'b0, NO_RES},
        '{8'h58,     1'b1, '{1'b0, 8'h00, 8'd0, ST_MISS_CR, 9'd0}}
    };

    logic i_clk;
    logic i_rst_n;

    nsf_rx_if  rx_ch ();
    nsf_res_if res_ch ();

    nmea_sentence_framer #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_ch),
        .o_res  (res_ch)
    );

    // framer state as the predictor sees it
    int unsigned fr_pos;
    int unsigned fr_star;
    logic [7:0]  fr_xor;
    logic [7:0]  fr_chk_hi;
    logic [7:0]  fr_chk_lo;

    t_frame_res  pending_results [$];
    int          mismatch_count;
    int          sent_items;
    int          no_gap_left;
    bit          hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL nmea_sentence_framer");
        $finish;
    end

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return (upper ? 8'h37 : 8'h57) + 8'(nib);
    endfunction

    function automatic t_frame_res stored_word(input logic [7:0] c, input int unsigned n);
        t_frame_res r;
        r = '0;
        r.stored = 1'b1;
        r.data   = c;
        r.pos    = 8'(n);
        r.status = ST_IN_FRAME;
        return r;
    endfunction

    // advances the predicted framer by one byte and returns the word it should produce
    function automatic t_frame_res frame_next_result(input logic [7:0] c);
        t_frame_res  r;
        int unsigned n;
        r = '0;
        n = fr_pos;
        if (n == 0) begin
            fr_xor  = 8'h00;
            fr_star = FRAME_MAX;
            if (c == CH_DOLLAR) begin
                fr_pos = 1;
                r = stored_word(c, 0);
            end else begin
                r.status = ST_IDLE;
            end
        end else if (n > FRAME_MAX) begin
            fr_pos   = 0;
            r.status = ST_OVERFLOW;
        end else if (c == CH_STAR) begin
            // a star restarts checksum capture wherever it falls
            fr_star = n;
            fr_pos  = n + 1;
            r = stored_word(c, n);
        end else if (n == fr_star + 1) begin
            fr_chk_hi = c;
            fr_pos    = n + 1;
            r = stored_word(c, n);
        end else if (n == fr_star + 2) begin
            fr_chk_lo = c;
            fr_pos    = n + 1;
            r = stored_word(c, n);
        end else if (n == fr_star + 3) begin
            if (c == CH_CR) begin
                fr_pos = n + 1;
                r = stored_word(c, n);
            end else begin
                fr_pos   = 0;
                r.status = ST_MISS_CR;
            end
        end else if (n == fr_star + 4) begin
            if (c == CH_LF) begin
                r = stored_word(c, n);
                r.len = 9'(n + 2);
                r.status = (fr_chk_hi == hex_ascii(fr_xor[7:4], 1'b1) &&
                            fr_chk_lo == hex_ascii(fr_xor[3:0], 1'b1)) ? ST_GOOD : ST_MISMATCH;
                fr_pos = 0;
            end else begin
                r.status = ST_IN_FRAME;
            end
        end else begin
            fr_xor = fr_xor ^ c;
            fr_pos = n + 1;
            r = stored_word(c, n);
        end
        return r;
    endfunction

    function automatic int sender_gap();
        int pick;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            no_gap_left = $urandom_range(20, 60);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed, input t_frame_res typed_res);
        int gap;
        t_frame_res r;
        gap = sender_gap();
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        r = frame_next_result(b);
        pending_results.push_back(typed ? typed_res : r);
        sent_items++;
    endtask

    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic send_random_byte();
        send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);
    endtask

    // mostly well-formed sentences with random content, some broken on purpose
    task automatic send_sentence(input bit force_long);
        int         body_len;
        int         pick;
        logic [7:0] b;
        logic [7:0] sum;
        bit         upper;
        sum = 8'h00;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_random_byte();
        end
        send_byte(CH_DOLLAR, 1'b0, NO_RES);
        if (force_long || $urandom_range(0, 39) == 0) begin
            body_len = $urandom_range(250, 262);
        end else begin
            body_len = $urandom_range(0, 24);
        end
        repeat (body_len) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_STAR && $urandom_range(0, 7) != 0) begin
                b = 8'h2C;
            end
            sum = sum ^ b;
            send_byte(b, 1'b0, NO_RES);
        end
        send_byte(CH_STAR, 1'b0, NO_RES);
        pick = $urandom_range(0, 9);
        if (pick < 9) begin
            upper = (pick < 8);
            send_byte(hex_ascii(sum[7:4], upper), 1'b0, NO_RES);
            send_byte(hex_ascii(sum[3:0], upper), 1'b0, NO_RES);
        end else begin
            send_random_byte();
            send_random_byte();
        end
        pick = $urandom_range(0, 29);
        if (pick == 0) begin
            send_byte(CH_STAR, 1'b0, NO_RES);
        end else if (pick < 3) begin
            send_random_byte();
        end else begin
            send_byte(CH_CR, 1'b0, NO_RES);
        end
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) send_random_byte();
        end
        send_byte(CH_LF, 1'b0, NO_RES);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got status %0d byte %0h",
                         $time, res_ch.status, res_ch.frame_byte);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("byte_stored", want.stored, res_ch.byte_stored);
                check_field("frame_byte", want.data, res_ch.frame_byte);
                check_field("byte_position", want.pos, res_ch.byte_position);
                check_field("status", want.status, res_ch.status);
                check_field("frame_length", want.len, res_ch.frame_length);
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int run;
        int stall;
        int pick;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            res_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            pick = $urandom_range(0, 99);
            if (hold_off_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (pick < 70) begin
                stall = $urandom_range(1, 3);
            end else if (pick < 95) begin
                stall = $urandom_range(4, 10);
            end else begin
                stall = $urandom_range(20, 60);
            end
            res_ch.ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
    end

    initial begin
        int sentence_count;
        i_rst_n        <= 1'b0;
        rx_ch.valid    <= 1'b0;
        rx_ch.rx_byte  <= 8'h00;
        res_ch.ready   <= 1'b0;
        mismatch_count = 0;
        sent_items     = 0;
        no_gap_left    = 0;
        hold_off_req   = 1'b0;
        sentence_count = 0;
        fr_pos    = 0;
        fr_star   = FRAME_MAX;
        fr_xor    = 8'h00;
        fr_chk_hi = 8'h00;
        fr_chk_lo = 8'h00;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_COUNT; i++) begin
            send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end
        drain_results();

        // long stall on the result side while words keep coming
        hold_off_req = 1'b1;
        while (sent_items < DIR_COUNT + RANDOM_ITEMS) begin
            send_sentence(sentence_count == 4);
            sentence_count++;
            if ($urandom_range(0, 19) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS nmea_sentence_framer");
        end else begin
            $display("FAIL nmea_sentence_framer");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/nsf_pkg.sv
hdl/nsf_rx_if.sv
hdl/nsf_res_if.sv
hdl/nsf_front.sv
hdl/nsf_queue.sv
hdl/nsf_back.sv
hdl/nmea_sentence_framer.sv
verif/testbench.sv
